FILE: hdl/tpp_pkg.sv
// Package for the trapezoidal position profile block.
// Holds widths, register indexes, codes and the shared multiply unit command type.
// No dependencies; every other file of the block uses it by scoped names.
package tpp_pkg;

  // Fixed point format
  localparam int POS_BITS  = 24;
  localparam int FRAC_BITS = 16;
  localparam int TIME_FRAC = 16;

  // Field and register widths
  localparam int CFG_W      = 24;
  localparam int LIMIT_W    = 32;
  localparam int MODE_W     = 3;
  localparam int DT_W       = 16;
  localparam int TGT_W      = 25;
  localparam int TGT_MAG_W  = TGT_W - 1;
  localparam int STAT_W     = 2;
  localparam int ELAP_W     = 33;
  localparam int IDX_W      = 3;
  localparam int CFG_DATA_W = 32;

  // Derived datapath widths
  localparam int VEL_W   = POS_BITS + FRAC_BITS;
  localparam int MW_A    = (POS_BITS > CFG_W) ? POS_BITS : CFG_W;
  localparam int MW_B    = (FRAC_BITS > DT_W) ? FRAC_BITS : DT_W;
  localparam int MW      = (MW_A > MW_B) ? MW_A : MW_B;
  localparam int PROD_W  = 2 * MW;
  localparam int ACC_W   = (2 * VEL_W > PROD_W) ? 2 * VEL_W : PROD_W;
  localparam int UP_SH   = (FRAC_BITS >= TIME_FRAC) ? FRAC_BITS - TIME_FRAC : 0;
  localparam int DN_SH   = (FRAC_BITS < TIME_FRAC) ? TIME_FRAC - FRAC_BITS : 0;
  localparam int DV_W    = CFG_W + DT_W + UP_SH;
  localparam int DVF_W   = PROD_W + UP_SH;
  localparam int SUM_A   = (VEL_W > DV_W) ? VEL_W : DV_W;
  localparam int SUM_B   = CFG_W + FRAC_BITS;
  localparam int SUM_W   = ((SUM_A > SUM_B) ? SUM_A : SUM_B) + 1;
  localparam int L_W     = 2 * CFG_W + 1;
  localparam int CMP_A   = L_W + 2 * FRAC_BITS;
  localparam int CMP_W   = (CMP_A > 2 * VEL_W) ? CMP_A : 2 * VEL_W;
  localparam int SP_A    = (POS_BITS + 1 > CFG_W) ? POS_BITS + 1 : CFG_W;
  localparam int SP_W    = ((SP_A > TGT_MAG_W) ? SP_A : TGT_MAG_W) + 1;
  localparam int STEP_LO = FRAC_BITS + TIME_FRAC;
  localparam int DIV_CNT_W = $clog2(PROD_W + 1);

  localparam logic [TGT_MAG_W-1:0] TARGET_MAX = {TGT_MAG_W{1'b1}};

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_MAX_ACCEL    = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAX_VELOCITY = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_DECEL    = 3'd2;
  localparam logic [IDX_W-1:0] REG_OUTER_LENGTH = 3'd3;
  localparam logic [IDX_W-1:0] REG_INNER_LENGTH = 3'd4;
  localparam logic [IDX_W-1:0] REG_TIME_LIMIT   = 3'd5;
  localparam logic [IDX_W-1:0] REG_MOVE_MODE    = 3'd6;

  // Move mode bit positions
  localparam int MODE_TURN = 0;
  localparam int MODE_REV  = 1;
  localparam int MODE_STOP = 2;

  // Request operations
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_RUNNING = 2'd0;
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd1;
  localparam logic [STAT_W-1:0] ST_TIMEOUT = 2'd2;

  // Shared multiply unit: product alignment and command
  typedef enum logic [1:0] {
    SH_NONE,
    SH_FRAC,
    SH_FRAC1,
    SH_FRAC2
  } mac_shift_e;

  typedef struct packed {
    logic       issue;
    logic       add;
    mac_shift_e shift;
  } mac_cmd_t;

endpackage

FILE: hdl/tpp_if.sv
// Request and result channel interfaces of the trapezoidal position profile block.
// Valid/ready handshake with payload; widths come from tpp_pkg.
interface tpp_req_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [tpp_pkg::DT_W-1:0]    delta_time;

  modport source (output valid, output op, output delta_time, input ready);
  modport sink   (input valid, input op, input delta_time, output ready);
endinterface

interface tpp_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [tpp_pkg::TGT_W-1:0]  left_target;
  logic signed [tpp_pkg::TGT_W-1:0]  right_target;
  logic [tpp_pkg::STAT_W-1:0]        status;

  modport source (output valid, output left_target, output right_target, output status,
                  input ready);
  modport sink   (input valid, input left_target, input right_target, input status,
                  output ready);
endinterface

FILE: hdl/tpp_mac.sv
// Shared multiply-accumulate unit of the profile block.
// Registered product, then a shifted load or add into a wide accumulator; uses tpp_pkg.
module tpp_mac (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tpp_pkg::mac_cmd_t            cmd_i,
  input  logic [tpp_pkg::MW-1:0]       op_a_i,
  input  logic [tpp_pkg::MW-1:0]       op_b_i,
  output logic [tpp_pkg::ACC_W-1:0]    acc_o
);

  tpp_pkg::mac_cmd_t                 cmd_q;
  logic [tpp_pkg::PROD_W-1:0]        prod_q;
  logic [tpp_pkg::ACC_W-1:0]         acc_q;
  logic [tpp_pkg::ACC_W-1:0]         prod_ext;
  logic [tpp_pkg::ACC_W-1:0]         prod_sh;
  logic [tpp_pkg::ACC_W-1:0]         base;

  // Align the product for the partial product it stands for
  always_comb begin
    prod_ext = tpp_pkg::ACC_W'(prod_q);
    unique case (cmd_q.shift)
      tpp_pkg::SH_NONE:  prod_sh = prod_ext;
      tpp_pkg::SH_FRAC:  prod_sh = prod_ext << tpp_pkg::FRAC_BITS;
      tpp_pkg::SH_FRAC1: prod_sh = prod_ext << (tpp_pkg::FRAC_BITS + 1);
      tpp_pkg::SH_FRAC2: prod_sh = prod_ext << (2 * tpp_pkg::FRAC_BITS);
      default:           prod_sh = prod_ext;
    endcase
    base = cmd_q.add ? acc_q : '0;
  end

  // Hold command flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= '0;
    end else begin
      cmd_q <= cmd_i;
    end
  end

  // Multiply, then load or accumulate the registered product in the next cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      prod_q <= tpp_pkg::PROD_W'(op_a_i) * tpp_pkg::PROD_W'(op_b_i);
    end
    if (cmd_q.issue) begin
      acc_q <= base + prod_sh;
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: hdl/tpp_div.sv
// Restoring divider of the profile block, one quotient bit per cycle.
// Used for the inner wheel ratio in turn mode; uses tpp_pkg widths.
module tpp_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tpp_pkg::PROD_W-1:0]    dividend_i,
  input  logic [tpp_pkg::CFG_W-1:0]     divisor_i,
  output logic                          done_o,
  output logic [tpp_pkg::PROD_W-1:0]    quot_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [tpp_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [tpp_pkg::CFG_W-1:0]         rem_q;
  logic [tpp_pkg::CFG_W-1:0]         dsr_q;
  logic [tpp_pkg::PROD_W-1:0]        quo_q;
  logic [tpp_pkg::CFG_W:0]           trial;
  logic [tpp_pkg::CFG_W:0]           trial_sub;
  logic                              fits;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    trial     = {rem_q, quo_q[tpp_pkg::PROD_W-1]};
    trial_sub = trial - {1'b0, dsr_q};
    fits      = (trial >= {1'b0, dsr_q});
  end

  // Control: count iterations, pulse done after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= tpp_pkg::DIV_CNT_W'(tpp_pkg::PROD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - tpp_pkg::DIV_CNT_W'(1);
        if (cnt_q == tpp_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dsr_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial_sub[tpp_pkg::CFG_W-1:0] : trial[tpp_pkg::CFG_W-1:0];
      quo_q <= {quo_q[tpp_pkg::PROD_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

FILE: hdl/trapezoidal_position_profile_top.sv
// Trapezoidal position profile for a two-wheel drive, top level with the sequencer.
// A start or an idle tick goes straight to the emit state; a running tick first steps
// through the multiply states, in turn mode also the divider. A request is taken only in
// idle; a result waits in an output register, a second one in the emit state.
// Reset (async, active low) clears configuration, velocity, setpoint, time and targets;
// the held status resets to done. Depends on tpp_pkg, tpp_if, tpp_mac and tpp_div.
module trapezoidal_position_profile_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tpp_pkg::IDX_W-1:0]         cfg_idx_i,
  input  logic [tpp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  tpp_req_if.sink                           req_i,
  tpp_rsp_if.source                         rsp_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DV, S_L, S_SQ0, S_SQ1, S_SQ2, S_SQW, S_VEL, S_ST0, S_ST1, S_STW,
    S_POS, S_INNER, S_INW, S_DIVGO, S_DIV, S_TGT, S_EMIT
  } state_e;

  state_e state_q;

  // Configuration
  logic [tpp_pkg::CFG_W-1:0]    max_accel_q, max_velocity_q, min_decel_q;
  logic [tpp_pkg::CFG_W-1:0]    outer_q, inner_len_q;
  logic [tpp_pkg::LIMIT_W-1:0]  time_limit_q;
  logic [tpp_pkg::MODE_W-1:0]   mode_q;

  // Profile state
  logic [tpp_pkg::VEL_W-1:0]    velocity_q;
  logic [tpp_pkg::POS_BITS-1:0] setpoint_q;
  logic [tpp_pkg::ELAP_W-1:0]   elapsed_q;
  logic                         running_q;
  logic signed [tpp_pkg::TGT_W-1:0] last_left_q, last_right_q;
  logic [tpp_pkg::STAT_W-1:0]   held_status_q;

  // Working registers
  logic [tpp_pkg::DT_W-1:0]     dt_q;
  logic [tpp_pkg::DV_W-1:0]     dv_q;
  logic [tpp_pkg::L_W-1:0]      l_q;
  logic [tpp_pkg::TGT_MAG_W-1:0] inner_q;

  // Output register
  logic                             rsp_valid_q;
  logic signed [tpp_pkg::TGT_W-1:0] rsp_left_q, rsp_right_q;
  logic [tpp_pkg::STAT_W-1:0]       rsp_status_q;

  // Shared unit connections
  tpp_pkg::mac_cmd_t            mac_cmd;
  logic [tpp_pkg::MW-1:0]       mac_a, mac_b;
  logic [tpp_pkg::ACC_W-1:0]    acc;
  logic                         div_start, div_done;
  logic [tpp_pkg::PROD_W-1:0]   div_quot;

  // Combinational datapath
  logic                         accept;
  logic [tpp_pkg::FRAC_BITS-1:0] vel_lo;
  logic [tpp_pkg::POS_BITS-1:0] vel_hi;
  logic [tpp_pkg::SP_W-1:0]     sp_ext, outer_ext;
  logic                         over;
  logic [tpp_pkg::CFG_W-1:0]    diff;
  logic [tpp_pkg::DVF_W-1:0]    dv_full;
  logic [tpp_pkg::CMP_W-1:0]    cmp_lhs, cmp_rhs;
  logic                         slow;
  logic [tpp_pkg::SUM_W-1:0]    vel_ext, dv_ext, vmin_ext, vmax_ext, vtop_ext;
  logic [tpp_pkg::SUM_W-1:0]    vel_dec, vel_inc, vel_new;
  logic [tpp_pkg::POS_BITS-1:0] step;
  logic [tpp_pkg::SP_W-1:0]     sp_sum, sp_new;
  logic [tpp_pkg::TGT_MAG_W-1:0] sp_mag, inner_sat;
  logic signed [tpp_pkg::TGT_W-1:0] sp_pos, sp_neg, in_pos, in_neg;
  logic signed [tpp_pkg::TGT_W-1:0] left_new, right_new;
  logic                         move_end;
  logic [tpp_pkg::STAT_W-1:0]   status_new;
  logic                         emit_ok;

  assign accept  = req_i.valid && req_i.ready;
  assign emit_ok = !rsp_valid_q || rsp_o.ready;

  // Velocity split and distance to go
  always_comb begin
    vel_lo    = velocity_q[tpp_pkg::FRAC_BITS-1:0];
    vel_hi    = velocity_q[tpp_pkg::VEL_W-1:tpp_pkg::FRAC_BITS];
    sp_ext    = tpp_pkg::SP_W'(setpoint_q);
    outer_ext = tpp_pkg::SP_W'(outer_q);
    over      = sp_ext > outer_ext;
    diff      = outer_q - tpp_pkg::CFG_W'(setpoint_q);
    dv_full   = (tpp_pkg::DVF_W'(acc[tpp_pkg::PROD_W-1:0]) << tpp_pkg::UP_SH)
                >> tpp_pkg::DN_SH;
  end

  // Select operands for the shared multiplier
  always_comb begin
    mac_cmd = '{issue: 1'b0, add: 1'b0, shift: tpp_pkg::SH_NONE};
    mac_a   = '0;
    mac_b   = '0;
    unique case (state_q)
      S_DV: begin
        mac_cmd.issue = 1'b1;
        mac_a = tpp_pkg::MW'(max_accel_q);
        mac_b = tpp_pkg::MW'(dt_q);
      end
      S_L: begin
        mac_cmd.issue = 1'b1;
        mac_a = tpp_pkg::MW'(diff);
        mac_b = tpp_pkg::MW'(max_accel_q);
      end
      S_SQ0: begin
        mac_cmd.issue = 1'b1;
        mac_a = tpp_pkg::MW'(vel_lo);
        mac_b = tpp_pkg::MW'(vel_lo);
      end
      S_SQ1: begin
        mac_cmd = '{issue: 1'b1, add: 1'b1, shift: tpp_pkg::SH_FRAC1};
        mac_a = tpp_pkg::MW'(vel_hi);
        mac_b = tpp_pkg::MW'(vel_lo);
      end
      S_SQ2: begin
        mac_cmd = '{issue: 1'b1, add: 1'b1, shift: tpp_pkg::SH_FRAC2};
        mac_a = tpp_pkg::MW'(vel_hi);
        mac_b = tpp_pkg::MW'(vel_hi);
      end
      S_ST0: begin
        mac_cmd.issue = 1'b1;
        mac_a = tpp_pkg::MW'(vel_lo);
        mac_b = tpp_pkg::MW'(dt_q);
      end
      S_ST1: begin
        mac_cmd = '{issue: 1'b1, add: 1'b1, shift: tpp_pkg::SH_FRAC};
        mac_a = tpp_pkg::MW'(vel_hi);
        mac_b = tpp_pkg::MW'(dt_q);
      end
      S_INNER: begin
        mac_cmd.issue = 1'b1;
        mac_a = tpp_pkg::MW'(setpoint_q);
        mac_b = tpp_pkg::MW'(inner_len_q);
      end
      default: ;
    endcase
  end

  // Slow-down decision and new velocity
  always_comb begin
    cmp_lhs = tpp_pkg::CMP_W'(l_q) << (2 * tpp_pkg::FRAC_BITS);
    cmp_rhs = tpp_pkg::CMP_W'(acc[2*tpp_pkg::VEL_W-1:0]);
    if (!mode_q[tpp_pkg::MODE_STOP]) begin
      slow = 1'b0;
    end else if (over) begin
      slow = (max_accel_q != '0) || (velocity_q != '0);
    end else begin
      slow = cmp_lhs < cmp_rhs;
    end
    vel_ext  = tpp_pkg::SUM_W'(velocity_q);
    dv_ext   = tpp_pkg::SUM_W'(dv_q);
    vmin_ext = tpp_pkg::SUM_W'(min_decel_q) << tpp_pkg::FRAC_BITS;
    vmax_ext = tpp_pkg::SUM_W'(max_velocity_q) << tpp_pkg::FRAC_BITS;
    vtop_ext = tpp_pkg::SUM_W'({tpp_pkg::VEL_W{1'b1}});
    vel_dec  = (dv_ext > vel_ext) ? '0 : vel_ext - dv_ext;
    if (vel_dec < vmin_ext) vel_dec = vmin_ext;
    vel_inc  = vel_ext + dv_ext;
    if (vel_inc > vmax_ext) vel_inc = vmax_ext;
    vel_new  = slow ? vel_dec : vel_inc;
    if (vel_new > vtop_ext) vel_new = vtop_ext;
  end

  // Advance and clamp the setpoint
  always_comb begin
    step   = acc[tpp_pkg::STEP_LO +: tpp_pkg::POS_BITS];
    sp_sum = sp_ext + tpp_pkg::SP_W'(step);
    sp_new = (sp_sum > outer_ext) ? outer_ext : sp_sum;
  end

  // Wheel targets and move status
  always_comb begin
    sp_mag    = (sp_ext > tpp_pkg::SP_W'(tpp_pkg::TARGET_MAX)) ? tpp_pkg::TARGET_MAX
                : tpp_pkg::TGT_MAG_W'(setpoint_q);
    inner_sat = (div_quot > tpp_pkg::PROD_W'(tpp_pkg::TARGET_MAX)) ? tpp_pkg::TARGET_MAX
                : div_quot[tpp_pkg::TGT_MAG_W-1:0];
    sp_pos    = $signed({1'b0, sp_mag});
    sp_neg    = -sp_pos;
    in_pos    = $signed({1'b0, inner_q});
    in_neg    = -in_pos;
    if (mode_q[tpp_pkg::MODE_TURN]) begin
      if (mode_q[tpp_pkg::MODE_REV]) begin
        left_new  = in_neg;
        right_new = sp_pos;
      end else begin
        left_new  = sp_neg;
        right_new = in_pos;
      end
    end else if (mode_q[tpp_pkg::MODE_REV]) begin
      left_new  = sp_pos;
      right_new = sp_neg;
    end else begin
      left_new  = sp_neg;
      right_new = sp_pos;
    end
    move_end = (sp_ext >= outer_ext) ||
               (elapsed_q >= tpp_pkg::ELAP_W'(time_limit_q));
    if (!move_end) begin
      status_new = tpp_pkg::ST_RUNNING;
    end else if (elapsed_q > tpp_pkg::ELAP_W'(time_limit_q)) begin
      status_new = tpp_pkg::ST_TIMEOUT;
    end else begin
      status_new = tpp_pkg::ST_DONE;
    end
  end

  assign div_start = (state_q == S_DIVGO) && (outer_q != '0);

  // Sequencer, profile state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      max_accel_q    <= '0;
      max_velocity_q <= '0;
      min_decel_q    <= '0;
      outer_q        <= '0;
      inner_len_q    <= '0;
      time_limit_q   <= '0;
      mode_q         <= '0;
      velocity_q     <= '0;
      setpoint_q     <= '0;
      elapsed_q      <= '0;
      running_q      <= 1'b0;
      last_left_q    <= '0;
      last_right_q   <= '0;
      held_status_q  <= tpp_pkg::ST_DONE;
      dt_q           <= '0;
      dv_q           <= '0;
      l_q            <= '0;
      inner_q        <= '0;
      rsp_valid_q    <= 1'b0;
      rsp_left_q     <= '0;
      rsp_right_q    <= '0;
      rsp_status_q   <= tpp_pkg::ST_RUNNING;
    end else begin
      // Configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tpp_pkg::REG_MAX_ACCEL:    max_accel_q    <= cfg_data_i[tpp_pkg::CFG_W-1:0];
          tpp_pkg::REG_MAX_VELOCITY: max_velocity_q <= cfg_data_i[tpp_pkg::CFG_W-1:0];
          tpp_pkg::REG_MIN_DECEL:    min_decel_q    <= cfg_data_i[tpp_pkg::CFG_W-1:0];
          tpp_pkg::REG_OUTER_LENGTH: outer_q        <= cfg_data_i[tpp_pkg::CFG_W-1:0];
          tpp_pkg::REG_INNER_LENGTH: inner_len_q    <= cfg_data_i[tpp_pkg::CFG_W-1:0];
          tpp_pkg::REG_TIME_LIMIT:   time_limit_q   <= cfg_data_i[tpp_pkg::LIMIT_W-1:0];
          tpp_pkg::REG_MOVE_MODE:    mode_q         <= cfg_data_i[tpp_pkg::MODE_W-1:0];
          default: ;
        endcase
      end

      // Load a finished result, or drop one once taken
      if ((state_q == S_EMIT) && emit_ok) begin
        rsp_valid_q  <= 1'b1;
        rsp_left_q   <= last_left_q;
        rsp_right_q  <= last_right_q;
        rsp_status_q <= held_status_q;
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            dt_q <= req_i.delta_time;
            if (req_i.op == tpp_pkg::OP_START) begin
              setpoint_q   <= '0;
              elapsed_q    <= '0;
              last_left_q  <= '0;
              last_right_q <= '0;
              if ((outer_q == '0) || (time_limit_q == '0)) begin
                running_q     <= 1'b0;
                held_status_q <= tpp_pkg::ST_DONE;
              end else begin
                running_q     <= 1'b1;
                held_status_q <= tpp_pkg::ST_RUNNING;
              end
              state_q <= S_EMIT;
            end else if (!running_q) begin
              state_q <= S_EMIT;
            end else begin
              elapsed_q <= elapsed_q + tpp_pkg::ELAP_W'(req_i.delta_time);
              state_q   <= S_DV;
            end
          end
        end
        S_DV:  state_q <= S_L;
        S_L:   state_q <= S_SQ0;
        S_SQ0: begin
          dv_q    <= dv_full[tpp_pkg::DV_W-1:0];
          state_q <= S_SQ1;
        end
        S_SQ1: begin
          l_q     <= {acc[tpp_pkg::L_W-2:0], 1'b0};
          state_q <= S_SQ2;
        end
        S_SQ2: state_q <= S_SQW;
        S_SQW: state_q <= S_VEL;
        S_VEL: begin
          velocity_q <= vel_new[tpp_pkg::VEL_W-1:0];
          state_q    <= S_ST0;
        end
        S_ST0: state_q <= S_ST1;
        S_ST1: state_q <= S_STW;
        S_STW: state_q <= S_POS;
        S_POS: begin
          setpoint_q <= sp_new[tpp_pkg::POS_BITS-1:0];
          state_q    <= mode_q[tpp_pkg::MODE_TURN] ? S_INNER : S_TGT;
        end
        S_INNER: state_q <= S_INW;
        S_INW:   state_q <= S_DIVGO;
        S_DIVGO: begin
          if (outer_q == '0) begin
            inner_q <= '0;
            state_q <= S_TGT;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            inner_q <= inner_sat;
            state_q <= S_TGT;
          end
        end
        S_TGT: begin
          last_left_q   <= left_new;
          last_right_q  <= right_new;
          held_status_q <= status_new;
          if (move_end) begin
            running_q <= 1'b0;
          end
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_ok) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  tpp_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .op_a_i (mac_a),
    .op_b_i (mac_b),
    .acc_o  (acc)
  );

  tpp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc[tpp_pkg::PROD_W-1:0]),
    .divisor_i  (outer_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Drive the channels
  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.left_target  = rsp_left_q;
  assign rsp_o.right_target = rsp_right_q;
  assign rsp_o.status       = rsp_status_q;

endmodule

FILE: tb/profile_check_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the trapezoidal position profile testbench: predicts targets and status
// for every accepted request and checks results against them in order.
// Depends on tpp_pkg for widths, register indexes, operations and status codes.
package profile_check_pkg;
  import tpp_pkg::*;

  localparam bit [63:0] VEL_SAT = (64'd1 << VEL_W) - 1;

  typedef struct packed {
    logic [TGT_W-1:0]  left;
    logic [TGT_W-1:0]  right;
    logic [STAT_W-1:0] status;
  } wheel_result_t;

  class profile_scoreboard;
    // Register copy
    bit [CFG_W-1:0]    accel;
    bit [CFG_W-1:0]    vel_cap;
    bit [CFG_W-1:0]    vel_floor;
    bit [CFG_W-1:0]    outer_len;
    bit [CFG_W-1:0]    inner_len;
    bit [LIMIT_W-1:0]  time_lim;
    bit [MODE_W-1:0]   mode;
    // Profile state
    bit [VEL_W-1:0]    vel;
    bit [POS_BITS-1:0] setpt;
    bit [ELAP_W-1:0]   elapsed_t;
    bit                moving;
    bit [TGT_W-1:0]    held_left;
    bit [TGT_W-1:0]    held_right;
    bit [STAT_W-1:0]   held_status;
    wheel_result_t     expected_q[$];
    int                n_fail;

    function new();
      accel = 0;
      vel_cap = 0;
      vel_floor = 0;
      outer_len = 0;
      inner_len = 0;
      time_lim = 0;
      mode = 0;
      vel = 0;
      setpt = 0;
      elapsed_t = 0;
      moving = 1'b0;
      held_left = 0;
      held_right = 0;
      held_status = ST_DONE;
      n_fail = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit is_moving();
      return moving;
    endfunction

    function void apply_reg(logic [IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MAX_ACCEL:    accel = data[CFG_W-1:0];
        REG_MAX_VELOCITY: vel_cap = data[CFG_W-1:0];
        REG_MIN_DECEL:    vel_floor = data[CFG_W-1:0];
        REG_OUTER_LENGTH: outer_len = data[CFG_W-1:0];
        REG_INNER_LENGTH: inner_len = data[CFG_W-1:0];
        REG_TIME_LIMIT:   time_lim = data[LIMIT_W-1:0];
        REG_MOVE_MODE:    mode = data[MODE_W-1:0];
        default: ;
      endcase
    endfunction

    // Clamp a signed target to the output magnitude range
    function logic [TGT_W-1:0] clamp_target(longint v);
      longint lim;
      lim = longint'(TARGET_MAX);
      if (v > lim) v = lim;
      else if (v < -lim) v = -lim;
      return v[TGT_W-1:0];
    endfunction

    // Advance velocity and setpoint by one tick of dt
    function void advance(logic [DT_W-1:0] dt);
      bit [127:0] room;
      bit [127:0] vsq;
      bit [63:0]  dv;
      bit [63:0]  nv;
      bit [63:0]  step;
      bit [63:0]  sp_n;
      bit         slow;
      elapsed_t = elapsed_t + dt;
      dv = ((64'(accel) * 64'(dt)) << UP_SH) >> DN_SH;
      slow = 1'b0;
      if (mode[MODE_STOP]) begin
        if (setpt > outer_len) begin
          slow = (accel != 0) || (vel != 0);
        end else begin
          room = 128'(outer_len - setpt);
          room = (room * 128'(accel) * 128'd2) << (2 * FRAC_BITS);
          vsq = 128'(vel) * 128'(vel);
          slow = room < vsq;
        end
      end
      if (slow) begin
        nv = (dv > 64'(vel)) ? 64'd0 : 64'(vel) - dv;
        if (nv < (64'(vel_floor) << FRAC_BITS)) nv = 64'(vel_floor) << FRAC_BITS;
      end else begin
        nv = 64'(vel) + dv;
        if (nv > (64'(vel_cap) << FRAC_BITS)) nv = 64'(vel_cap) << FRAC_BITS;
      end
      if (nv > VEL_SAT) nv = VEL_SAT;
      vel = nv[VEL_W-1:0];
      step = (64'(vel) * 64'(dt)) >> STEP_LO;
      sp_n = 64'(setpt) + step;
      if (sp_n > 64'(outer_len)) sp_n = 64'(outer_len);
      setpt = sp_n[POS_BITS-1:0];
    endfunction

    // Work out the expected result of an accepted request
    function void note_request(logic op, logic [DT_W-1:0] dt);
      longint sp_s;
      longint inner_s;
      longint lft;
      longint rgt;
      if (op == OP_START) begin
        setpt = 0;
        elapsed_t = 0;
        held_left = 0;
        held_right = 0;
        moving = (outer_len != 0) && (time_lim != 0);
        held_status = moving ? ST_RUNNING : ST_DONE;
      end else if (moving) begin
        advance(dt);
        sp_s = longint'(setpt);
        if (mode[MODE_TURN]) begin
          inner_s = 0;
          if (outer_len != 0)
            inner_s = longint'((64'(setpt) * 64'(inner_len)) / 64'(outer_len));
          if (mode[MODE_REV]) begin
            lft = -inner_s;
            rgt = sp_s;
          end else begin
            lft = -sp_s;
            rgt = inner_s;
          end
        end else if (mode[MODE_REV]) begin
          lft = sp_s;
          rgt = -sp_s;
        end else begin
          lft = -sp_s;
          rgt = sp_s;
        end
        held_left = clamp_target(lft);
        held_right = clamp_target(rgt);
        if (setpt >= outer_len || elapsed_t >= time_lim) begin
          moving = 1'b0;
          held_status = (elapsed_t > time_lim) ? ST_TIMEOUT : ST_DONE;
        end else begin
          held_status = ST_RUNNING;
        end
      end
      expected_q.push_back({held_left, held_right, held_status});
    endfunction

    // Compare an accepted result with the oldest expectation
    function void check_result(logic [TGT_W-1:0] left, logic [TGT_W-1:0] right,
                               logic [STAT_W-1:0] status);
      wheel_result_t want;
      if (expected_q.size() == 0) begin
        if (n_fail < 10)
          $display("result with no request waiting: left %0d right %0d status %0d",
                   $signed(left), $signed(right), status);
        n_fail++;
        return;
      end
      want = expected_q.pop_front();
      if (want.left !== left || want.right !== right || want.status !== status) begin
        if (n_fail < 10)
          $display("mismatch: exp left %0d right %0d st %0d, got left %0d right %0d st %0d",
                   $signed(want.left), $signed(want.right), want.status,
                   $signed(left), $signed(right), status);
        n_fail++;
      end
    endfunction
  endclass

endpackage

FILE: tb/tb_trapezoidal_position_profile_top.sv
`timescale 1ns / 100ps
// Testbench top for trapezoidal_position_profile_top: directed and random moves with
// random idling on both channels, checked by profile_check_pkg's scoreboard.
// Depends on tpp_pkg, tpp_if, profile_check_pkg and the block's RTL.
module tb_trapezoidal_position_profile_top;
  import tpp_pkg::*;
  import profile_check_pkg::*;

  localparam int NUM_ITEMS    = 650;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 300;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [IDX_W-1:0]      cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  tpp_req_if req_if();
  tpp_rsp_if rsp_if();

  profile_scoreboard sb = new();

  int n_sent = 0;
  int req_gap_pct = 18;
  int rsp_gap_pct = 49;
  bit hold_rsp = 1'b0;

  trapezoidal_position_profile_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Offer one request, idling first at the current rate; note it when accepted
  task automatic send_req(input logic op, input logic [DT_W-1:0] dt);
    if (req_gap_pct > 0 && $urandom_range(99) < req_gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < req_gap_pct) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.op <= op;
    req_if.delta_time <= dt;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(op, dt);
    n_sent++;
    // swap idling sides, then run without idling
    req_gap_pct = (n_sent < 220) ? 18 : (n_sent < 440) ? 49 : 0;
    rsp_gap_pct = (n_sent < 220) ? 49 : (n_sent < 440) ? 18 : 0;
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.apply_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] mode_word(bit turn, bit rev, bit stop_end);
    return (CFG_DATA_W'(turn) << MODE_TURN) | (CFG_DATA_W'(rev) << MODE_REV) |
           (CFG_DATA_W'(stop_end) << MODE_STOP);
  endfunction

  // Mostly moderate values, with zero, full scale and full random mixed in
  function automatic logic [CFG_DATA_W-1:0] pick_value(int unsigned typical_hi, int width);
    logic [CFG_DATA_W-1:0] mask;
    int unsigned r;
    mask = {CFG_DATA_W{1'b1}} >> (CFG_DATA_W - width);
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 12) return mask;
    if (r < 30) return $urandom & mask;
    return $urandom_range(typical_hi, 1) & mask;
  endfunction

  function automatic logic [DT_W-1:0] rand_dt();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    if (r < 40) return DT_W'($urandom_range(2000, 1));
    return DT_W'($urandom_range(65535, 0));
  endfunction

  task automatic random_config();
    if ($urandom_range(9) < 6) write_reg(REG_MAX_ACCEL, pick_value(3000000, CFG_W));
    if ($urandom_range(9) < 6) write_reg(REG_MAX_VELOCITY, pick_value(2000000, CFG_W));
    if ($urandom_range(9) < 6) write_reg(REG_MIN_DECEL, pick_value(20000, CFG_W));
    if ($urandom_range(9) < 6) write_reg(REG_OUTER_LENGTH, pick_value(300000, CFG_W));
    if ($urandom_range(9) < 6) write_reg(REG_INNER_LENGTH, pick_value(400000, CFG_W));
    if ($urandom_range(9) < 6) write_reg(REG_TIME_LIMIT, pick_value(30 * 65536, LIMIT_W));
    if ($urandom_range(9) < 7) write_reg(REG_MOVE_MODE, CFG_DATA_W'($urandom_range(7)));
  endtask

  // One move: start, ticks until it ends or a cap is hit, with a rare restart
  task automatic random_move();
    int n_ticks;
    wait_drained();
    if ($urandom_range(9) < 7) random_config();
    send_req(OP_START, rand_dt());
    n_ticks = $urandom_range(40, 1);
    for (int k = 0; k < n_ticks && sb.is_moving(); k++) begin
      if ($urandom_range(99) < 3) send_req(OP_START, rand_dt());
      else send_req(OP_TICK, rand_dt());
    end
    repeat ($urandom_range(2)) send_req(OP_TICK, rand_dt());
  endtask

  // Result side: check accepted results, idle at random, hold off on request
  initial begin : rsp_side
    int hold_cnt;
    hold_cnt = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready)
        sb.check_result(rsp_if.left_target, rsp_if.right_target, rsp_if.status);
      if (hold_rsp) begin
        hold_cnt = HOLD_CYCLES;
        hold_rsp = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_gap_pct);
      end
    end
  end

  // End the run when nothing moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_MAX_ACCEL;
    cfg_data_i <= '0;
    req_if.valid <= 1'b0;
    req_if.op <= OP_START;
    req_if.delta_time <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Tick while idle after reset reports zero targets and done
    send_req(OP_TICK, 16'h1234);
    // Start with a zero end point finishes at once
    send_req(OP_START, '0);
    send_req(OP_TICK, '1);
    wait_drained();

    // Full scale straight move, then a tick after it has finished
    write_reg(REG_MAX_ACCEL, CFG_DATA_W'(24'hFFFFFF));
    write_reg(REG_MAX_VELOCITY, CFG_DATA_W'(24'hFFFFFF));
    write_reg(REG_MIN_DECEL, '0);
    write_reg(REG_OUTER_LENGTH, CFG_DATA_W'(24'hFFFFFF));
    write_reg(REG_INNER_LENGTH, '0);
    write_reg(REG_TIME_LIMIT, '1);
    write_reg(REG_MOVE_MODE, mode_word(0, 1, 0) & '0);
    send_req(OP_START, '0);
    send_req(OP_TICK, '1);
    send_req(OP_TICK, '1);
    send_req(OP_TICK, '0);
    wait_drained();

    // Reverse move with velocity carried in, zero and unit time steps
    write_reg(REG_MOVE_MODE, mode_word(0, 1, 0));
    send_req(OP_START, '1);
    send_req(OP_TICK, '0);
    send_req(OP_TICK, 16'd1);
    send_req(OP_TICK, '1);
    wait_drained();

    // Zero time limit: start ends at once
    write_reg(REG_TIME_LIMIT, '0);
    send_req(OP_START, '0);
    wait_drained();

    // Stop at end with zero acceleration: slow-down taken while moving
    write_reg(REG_MAX_ACCEL, '0);
    write_reg(REG_MIN_DECEL, CFG_DATA_W'(1000));
    write_reg(REG_OUTER_LENGTH, CFG_DATA_W'(5000));
    write_reg(REG_TIME_LIMIT, '1);
    write_reg(REG_MOVE_MODE, mode_word(0, 0, 1));
    send_req(OP_START, '0);
    send_req(OP_TICK, 16'd100);
    wait_drained();

    // Hard braking down to the velocity floor, then speeding up to the end
    write_reg(REG_MAX_ACCEL, CFG_DATA_W'(24'hFFFFFF));
    send_req(OP_START, '0);
    send_req(OP_TICK, '1);
    send_req(OP_TICK, '1);
    wait_drained();

    // Counterclockwise turn that overruns its time limit, then ends exactly on it
    write_reg(REG_TIME_LIMIT, CFG_DATA_W'(100));
    write_reg(REG_MOVE_MODE, mode_word(1, 1, 1));
    write_reg(REG_OUTER_LENGTH, CFG_DATA_W'(1000000));
    write_reg(REG_INNER_LENGTH, CFG_DATA_W'(300000));
    write_reg(REG_MAX_ACCEL, CFG_DATA_W'(1000));
    write_reg(REG_MAX_VELOCITY, CFG_DATA_W'(2000));
    write_reg(REG_MIN_DECEL, CFG_DATA_W'(10));
    send_req(OP_START, '0);
    send_req(OP_TICK, 16'd200);
    wait_drained();
    write_reg(REG_TIME_LIMIT, CFG_DATA_W'(200));
    send_req(OP_START, '0);
    send_req(OP_TICK, 16'd200);
    wait_drained();

    // Clockwise turn whose end point drops to zero mid-move
    write_reg(REG_TIME_LIMIT, '1);
    write_reg(REG_MOVE_MODE, mode_word(1, 0, 1));
    write_reg(REG_INNER_LENGTH, CFG_DATA_W'(2000000));
    send_req(OP_START, '0);
    send_req(OP_TICK, 16'd10);
    wait_drained();
    write_reg(REG_OUTER_LENGTH, '0);
    send_req(OP_TICK, 16'd10);

    // Random moves; in a window of the request count, hold the result side off while requests keep coming
    while (n_sent < NUM_ITEMS) begin
      if (n_sent >= 560 && n_sent < 600) begin
        wait_drained();
        hold_rsp = 1'b1;
        send_req(OP_START, rand_dt());
        repeat (8) send_req(OP_TICK, rand_dt());
      end
      random_move();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.n_fail == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
